### sv/ascu_pkg.sv
// ----------------------------------------------------------------------------
// ascu_pkg: shared constants of the step counter unit
// Widths, register indexes, item codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ascu_pkg;

  localparam int unsigned SampleBitsDef = 12;

  localparam int unsigned ThrW   = 13;
  localparam int unsigned TmrW   = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegStepThr  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRearmThr = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRefract  = 2'd2;

  // item codes
  localparam logic FuncSample = 1'b0;
  localparam logic FuncClear  = 1'b1;

  // register reset values
  localparam logic [ThrW-1:0] StepThrRst  = 13'd230;
  localparam logic [ThrW-1:0] RearmThrRst = 13'd200;
  localparam logic [TmrW-1:0] RefractRst  = 8'd5;

endpackage

### sv/ascu_if.sv
// ----------------------------------------------------------------------------
// ascu_if: valid/ready channels of the step counter unit
// Sample channel in, result channel out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ascu_in_if #(
  parameter int unsigned SAMPLE_BITS = ascu_pkg::SampleBitsDef
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;

  modport source (output valid, func, x_sample, y_sample, input ready);
  modport sink   (input valid, func, x_sample, y_sample, output ready);
endinterface

interface ascu_out_if #(
  parameter int unsigned SAMPLE_BITS = ascu_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic [ascu_pkg::CountW-1:0]   step_total;
  logic [SAMPLE_BITS:0]          movement;
  logic                          step_now;

  modport source (output valid, step_total, movement, step_now, input ready);
  modport sink   (input valid, step_total, movement, step_now, output ready);
endinterface

### sv/accel_step_counter_unit.sv
// ----------------------------------------------------------------------------
// accel_step_counter_unit: pedometer step detector on x/y samples
// Path: an input transfer reaches its result through the input reg and the result reg.
// Throughput: 1 item per cycle, set by the state update stage, while the result channel does not stall.
// Reset: thresholds 230/200, refractory 5, count 0, armed, previous sample 0.
// A clear item produces no result and leaves the update stage without waiting for a result slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_step_counter_unit #(
  parameter int unsigned SAMPLE_BITS = ascu_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ascu_in_if.sink                       in_if,
  ascu_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  logic [ascu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ascu_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SW   = SAMPLE_BITS;
  localparam int unsigned MvW  = SAMPLE_BITS + 1;
  // compare width covers both movement and threshold
  localparam int unsigned CmpW = (MvW > ascu_pkg::ThrW) ? MvW : ascu_pkg::ThrW;

  // configuration registers
  logic [ascu_pkg::ThrW-1:0] step_thr_q, rearm_thr_q;
  logic [ascu_pkg::TmrW-1:0] refract_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_thr_q  <= ascu_pkg::StepThrRst;
      rearm_thr_q <= ascu_pkg::RearmThrRst;
      refract_q   <= ascu_pkg::RefractRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ascu_pkg::RegStepThr:  step_thr_q  <= cfg_data_i[ascu_pkg::ThrW-1:0];
        ascu_pkg::RegRearmThr: rearm_thr_q <= cfg_data_i[ascu_pkg::ThrW-1:0];
        ascu_pkg::RegRefract:  refract_q   <= cfg_data_i[ascu_pkg::TmrW-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register stage
  // --------------------------------------------------------------------------
  logic          s1_valid_q;
  logic          s1_func_q;
  logic [SW-1:0] s1_x_q, s1_y_q;
  logic          s1_adv;
  logic          out_free;
  logic          out_load;

  // result register can take a new item when empty or being drained
  assign out_free = !out_if.valid || out_if.ready;
  // a clear item needs no result slot, so it always moves on
  assign s1_adv   = s1_valid_q && ((s1_func_q == ascu_pkg::FuncClear) || out_free);
  assign in_if.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_func_q <= in_if.func;
      s1_x_q    <= in_if.x_sample;
      s1_y_q    <= in_if.y_sample;
    end
  end

  // --------------------------------------------------------------------------
  // update stage: movement, refractory timer, step decision
  // --------------------------------------------------------------------------
  logic [SW-1:0]               last_x_q, last_y_q;
  logic [ascu_pkg::CountW-1:0] step_cnt_q, step_cnt_d;
  logic                        armed_q, armed_d;
  logic [ascu_pkg::TmrW-1:0]   tmr_q, tmr_d;

  logic [SW-1:0]               dx, dy;
  logic [MvW-1:0]              mv;
  logic [CmpW-1:0]             mv_cmp, step_cmp, rearm_cmp;
  logic [ascu_pkg::TmrW-1:0]   tmr_inc;
  logic                        armed_pre;
  logic [ascu_pkg::TmrW-1:0]   tmr_pre;
  logic                        step_hit;

  assign dx = (s1_x_q >= last_x_q) ? (s1_x_q - last_x_q) : (last_x_q - s1_x_q);
  assign dy = (s1_y_q >= last_y_q) ? (s1_y_q - last_y_q) : (last_y_q - s1_y_q);
  assign mv = MvW'(dx) + MvW'(dy);

  assign mv_cmp    = CmpW'(mv);
  assign step_cmp  = CmpW'(step_thr_q);
  assign rearm_cmp = CmpW'(rearm_thr_q);
  assign tmr_inc   = tmr_q + ascu_pkg::TmrW'(1);

  always_comb begin
    // refractory timer runs only while disarmed
    armed_pre = armed_q;
    tmr_pre   = tmr_q;
    if (!armed_q) begin
      if (tmr_inc >= refract_q) begin
        armed_pre = 1'b1;
        tmr_pre   = '0;
      end else begin
        tmr_pre   = tmr_inc;
      end
    end

    step_hit   = armed_pre && (mv_cmp > step_cmp);
    step_cnt_d = step_cnt_q;
    armed_d    = armed_pre;
    tmr_d      = tmr_pre;
    if (step_hit) begin
      step_cnt_d = step_cnt_q + ascu_pkg::CountW'(1);
      armed_d    = 1'b0;
      tmr_d      = '0;
    end
    // quiet movement re-arms, even right after a step
    if (mv_cmp < rearm_cmp) begin
      armed_d = 1'b1;
      tmr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q   <= '0;
      last_y_q   <= '0;
      step_cnt_q <= '0;
      armed_q    <= 1'b1;
      tmr_q      <= '0;
    end else if (s1_adv) begin
      if (s1_func_q == ascu_pkg::FuncClear) begin
        // clear keeps the previous sample and the timer
        step_cnt_q <= '0;
        armed_q    <= 1'b1;
      end else begin
        last_x_q   <= s1_x_q;
        last_y_q   <= s1_y_q;
        step_cnt_q <= step_cnt_d;
        armed_q    <= armed_d;
        tmr_q      <= tmr_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic                        out_valid_q;
  logic [ascu_pkg::CountW-1:0] out_total_q;
  logic [MvW-1:0]              out_mv_q;
  logic                        out_step_q;

  assign out_load = s1_adv && (s1_func_q == ascu_pkg::FuncSample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_total_q <= step_cnt_d;
      out_mv_q    <= mv;
      out_step_q  <= step_hit;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.step_total = out_total_q;
  assign out_if.movement   = out_mv_q;
  assign out_if.step_now   = out_step_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a clear transfer leaves the unit armed with a zero count
  a_clear_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_func_q == ascu_pkg::FuncClear) |=> armed_q && (step_cnt_q == '0))
    else $error("clear did not arm the unit or zero the count");

  // a counted step bumps the count by exactly one
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && step_hit |=> step_cnt_q == $past(step_cnt_q) + ascu_pkg::CountW'(1))
    else $error("step did not advance the count by one");

  // the result register is never overwritten while its result waits
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |-> !out_load)
    else $error("result register loaded while stalled");

endmodule
